### sv/cfu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cfu_pkg;

  // Fixed-point set-up
  localparam int CORDIC_STEPS  = 16;
  localparam int POS_FRAC_BITS = 16;
  localparam int CORDIC_ITER   = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int Q14_SH        = (POS_FRAC_BITS >= 14) ? POS_FRAC_BITS - 14
                                                       : 14 - POS_FRAC_BITS;

  // Datapath widths
  localparam int MIX_W      = 20;  // mixed vector before normalising
  localparam int NSQ_W      = 37;  // sum of squares
  localparam int SQ_W       = 52;  // radicand
  localparam int ROOT_W     = 26;  // vector length
  localparam int DIV_W      = 40;  // dividend and quotient
  localparam int SQRT_CNT_W = $clog2(ROOT_W + 1);
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

  localparam logic signed [25:0] DEG2RAD_Q30 = 26'sd18740330;
  localparam logic signed [33:0] CORDIC_X0   = 34'sd652032874;

  // Angle reduction
  localparam logic signed [35:0] FULL_TURN    = 36'(360) << POS_FRAC_BITS;
  localparam logic signed [35:0] HALF_TURN    = 36'(180) << POS_FRAC_BITS;
  localparam logic signed [35:0] QUARTER_TURN = 36'(90) << POS_FRAC_BITS;
  localparam int MOD_K = (POS_FRAC_BITS >= 23) ? 0 : 23 - POS_FRAC_BITS;
  localparam logic [33:0] FULL_TURN_U = 34'(FULL_TURN);
  localparam logic [33:0] MOD_WRAP    = 34'(FULL_TURN << MOD_K);

  typedef enum logic [1:0] {
    REQ_LOAD, REQ_MOVE_VEC, REQ_MOVE_AXIS, REQ_ROTATE
  } req_e;

  // Selector codes
  localparam logic [1:0] SEL_POS   = 2'd0;
  localparam logic [1:0] SEL_VIEW  = 2'd1;
  localparam logic [1:0] SEL_UP    = 2'd2;
  localparam logic [1:0] SEL_RIGHT = 2'd3;
  localparam logic [1:0] MOV_VIEW  = 2'd0;
  localparam logic [1:0] MOV_RIGHT = 2'd1;
  localparam logic [1:0] MOV_UP    = 2'd2;
  localparam logic [1:0] AX_NONE   = 2'd3;
  localparam logic [1:0] ROT_PITCH = 2'd0;
  localparam logic [1:0] ROT_YAW   = 2'd1;
  localparam logic [1:0] ROT_ROLL  = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_EXEC, ST_AX_MUL, ST_AX_ADD, ST_MOD, ST_FOLD, ST_RAD_MUL,
    ST_RAD_SH, ST_CORD_GO, ST_CORDIC, ST_MIX_A, ST_MIX_B, ST_MIX_C,
    ST_SQ_MUL, ST_SQ_ACC, ST_SQRT_GO, ST_SQRT, ST_DIV_GO, ST_DIV,
    ST_CR_A, ST_CR_B, ST_CR_C, ST_DONE
  } cfu_state_e;

  // Arctangent table, Q2.30
  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0:  r = 34'sd843314856;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043836;
      5'd3:  r = 34'sd133525158;
      5'd4:  r = 34'sd67021686;
      5'd5:  r = 34'sd33543515;
      5'd6:  r = 34'sd16775850;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194282;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048575;
      5'd11: r = 34'sd524287;
      5'd12: r = 34'sd262143;
      5'd13: r = 34'sd131071;
      5'd14: r = 34'sd65535;
      5'd15: r = 34'sd32767;
      5'd16: r = 34'sd16383;
      5'd17: r = 34'sd8191;
      5'd18: r = 34'sd4095;
      5'd19: r = 34'sd2047;
      5'd20: r = 34'sd1023;
      5'd21: r = 34'sd511;
      5'd22: r = 34'sd255;
      5'd23: r = 34'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    logic signed [15:0] r;
    if (v > 48'sd32767) r = 16'sh7fff;
    else if (v < -48'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    logic signed [31:0] r;
    if (v > 49'sd2147483647) r = 32'sh7fffffff;
    else if (v < -49'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Position format to Q2.14, saturated
  function automatic logic signed [15:0] to_q14(input logic signed [31:0] v);
    logic signed [47:0] w;
    w = 48'(v);
    if (POS_FRAC_BITS >= 14) w = w >>> Q14_SH;
    else w = w <<< Q14_SH;
    return sat16(w);
  endfunction

endpackage
`default_nettype wire

### sv/cfu_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
module cfu_cordic (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [33:0] angle_i,
  output logic                    done_o,
  output logic signed [17:0]      cos_o,
  output logic signed [17:0]      sin_o
);
  import cfu_pkg::*;

  logic signed [33:0] x_q, y_q, z_q;
  logic [4:0]         step_q;
  logic               busy_q, done_q;
  logic signed [33:0] x_sh, y_sh;

  // Shared shifter for the current step
  assign x_sh = x_q >>> step_q;
  assign y_sh = y_q >>> step_q;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == 5'(CORDIC_ITER)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q + 5'd1;
        end
      end
    end
  end

  // Micro-rotation
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= CORDIC_X0;
      y_q <= '0;
      z_q <= angle_i;
    end else if (busy_q && step_q != 5'(CORDIC_ITER)) begin
      if (!z_q[33]) begin
        x_q <= x_q - y_sh;
        y_q <= y_q + x_sh;
        z_q <= z_q - atan_q30(step_q);
      end else begin
        x_q <= x_q + y_sh;
        y_q <= y_q - x_sh;
        z_q <= z_q + atan_q30(step_q);
      end
    end
  end

  // Round to Q1.14
  assign cos_o  = 18'((x_q + 34'sd32768) >>> 16);
  assign sin_o  = 18'((y_q + 34'sd32768) >>> 16);
  assign done_o = done_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("cordic done while busy");
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> step_q <= 5'(CORDIC_ITER)) else $error("cordic step overrun");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && !start_i |=> !done_q) else $error("cordic done not a pulse");

endmodule
`default_nettype wire

### sv/cfu_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module cfu_isqrt (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [cfu_pkg::SQ_W-1:0]    radicand_i,
  output logic                             done_o,
  output logic [cfu_pkg::ROOT_W-1:0]       root_o
);
  import cfu_pkg::*;

  logic [SQ_W-1:0]       n_q;
  logic [ROOT_W+1:0]     rem_q, rem_n, trial;
  logic [ROOT_W-1:0]     root_q;
  logic [SQRT_CNT_W-1:0] cnt_q;
  logic                  busy_q, done_q;

  // Two radicand bits per step
  assign rem_n = {rem_q[ROOT_W-1:0], n_q[SQ_W-1:SQ_W-2]};
  assign trial = {root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= SQRT_CNT_W'(ROOT_W);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q    <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q && cnt_q != '0) begin
      n_q <= {n_q[SQ_W-3:0], 2'b00};
      if (rem_n >= trial) begin
        rem_q  <= rem_n - trial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_n;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

### sv/cfu_div.sv
`timescale 1ns / 1ps
`default_nettype none
module cfu_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [cfu_pkg::DIV_W-1:0]  dividend_i,
  input  wire logic [cfu_pkg::ROOT_W-1:0] divisor_i,
  output logic                            done_o,
  output logic [cfu_pkg::DIV_W-1:0]       quot_o
);
  import cfu_pkg::*;

  logic [DIV_W-1:0]     quot_q;
  logic [ROOT_W-1:0]    rem_q, dvs_q;
  logic [ROOT_W:0]      rem_n, rem_sub;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;

  // Restoring step, one quotient bit
  assign rem_n   = {rem_q, quot_q[DIV_W-1]};
  assign rem_sub = rem_n - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_W);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q && cnt_q != '0) begin
      if (rem_n >= {1'b0, dvs_q}) begin
        rem_q  <= rem_sub[ROOT_W-1:0];
        quot_q <= {quot_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_n[ROOT_W-1:0];
        quot_q <= {quot_q[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
`default_nettype wire

### sv/camera_frame_update.sv
// Load and move by vector go from the execute state straight to the result beat; move along
// an axis runs a multiply and an add per component; rotate runs an 8-step angle reduction,
// CORDIC sine and cosine, a square root, three divisions and the shared multiplier passes.
// Throughput: one command at a time; the next is taken once the sequencer returns to idle,
// even while the previous result beat still waits at the output register.
// Reset: asynchronous, active low; position and basis vectors clear to zero.
`timescale 1ns / 1ps
`default_nettype none
module camera_frame_update (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         req_type_i,
  input  wire logic [1:0]         axis_sel_i,
  input  wire logic signed [31:0] amount_i,
  input  wire logic signed [31:0] vec_x_i,
  input  wire logic signed [31:0] vec_y_i,
  input  wire logic signed [31:0] vec_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      pos_x_o,
  output logic signed [31:0]      pos_y_o,
  output logic signed [31:0]      pos_z_o,
  output logic signed [15:0]      view_x_o,
  output logic signed [15:0]      view_y_o,
  output logic signed [15:0]      view_z_o,
  output logic signed [15:0]      up_x_o,
  output logic signed [15:0]      up_y_o,
  output logic signed [15:0]      up_z_o,
  output logic signed [15:0]      right_x_o,
  output logic signed [15:0]      right_y_o,
  output logic signed [15:0]      right_z_o
);
  import cfu_pkg::*;

  cfu_state_e state_q, state_d;

  // Command beat
  req_e               req_q;
  logic [1:0]         ax_q;
  logic signed [31:0] amt_q;
  logic signed [31:0] vec_q [3];

  // Camera state
  logic signed [31:0] pos_q [3];
  logic signed [15:0] view_q [3];
  logic signed [15:0] up_q [3];
  logic signed [15:0] rgt_q [3];

  // Working registers
  logic [1:0]             idx_q;
  logic [4:0]             mod_cnt_q;
  logic [33:0]            mod_r_q;
  logic signed [32:0]     m_q;
  logic                   neg_q;
  logic signed [33:0]     z_q;
  logic signed [17:0]     c_q, s_q;
  logic signed [34:0]     acc_q;
  logic signed [MIX_W-1:0] t_q [3];
  logic [NSQ_W-1:0]       n2_q;
  logic [ROOT_W-1:0]      len_q;
  logic signed [58:0]     prod_q;

  // Output register
  logic                   out_valid_q;
  logic signed [31:0]     o_pos_q [3];
  logic signed [15:0]     o_view_q [3];
  logic signed [15:0]     o_up_q [3];
  logic signed [15:0]     o_rgt_q [3];

  logic in_acc, can_out, last_idx;
  logic cor_start, cor_done, sq_start, sq_done, dv_start, dv_done;
  logic signed [17:0] cor_cos, cor_sin;
  logic [ROOT_W-1:0]  sq_root;
  logic [DIV_W-1:0]   dv_quot, dv_dividend;
  logic [MIX_W-1:0]   t_abs;
  logic signed [32:0] mul_a;
  logic signed [25:0] mul_b;
  logic [1:0]         i1, i2, cr_ia, cr_ib;
  logic signed [15:0] mix_a_c, mix_b_c, cr_a_c, cr_b_c, axis_c, nrm_v;
  logic signed [17:0] mix_cb;
  logic signed [35:0] fm0, fm1;
  logic               fneg;
  logic [33:0]        mod_sub;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign can_out    = !out_valid_q || !out_stall_i;
  assign last_idx   = (idx_q == 2'd2);

  // Component indices for the cross product
  assign i1    = (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
  assign i2    = (idx_q == 2'd0) ? 2'd2 : idx_q - 2'd1;
  assign cr_ia = (state_q == ST_CR_A) ? i1 : i2;
  assign cr_ib = (state_q == ST_CR_A) ? i2 : i1;

  // Operand selection
  always_comb begin
    axis_c  = (ax_q == MOV_VIEW) ? view_q[idx_q] :
              (ax_q == MOV_RIGHT) ? rgt_q[idx_q] : up_q[idx_q];
    mix_a_c = (ax_q == ROT_ROLL) ? rgt_q[idx_q] : view_q[idx_q];
    mix_b_c = (ax_q == ROT_YAW) ? rgt_q[idx_q] : up_q[idx_q];
    mix_cb  = (ax_q == ROT_YAW) ? -s_q : s_q;
    cr_a_c  = (ax_q == ROT_YAW) ? view_q[cr_ia] : rgt_q[cr_ia];
    cr_b_c  = (ax_q == ROT_YAW) ? up_q[cr_ib] : view_q[cr_ib];
  end

  // Shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_AX_MUL:  begin mul_a = 33'(amt_q);    mul_b = 26'(axis_c);   end
      ST_RAD_MUL: begin mul_a = m_q;           mul_b = DEG2RAD_Q30;   end
      ST_MIX_A:   begin mul_a = 33'(mix_a_c);  mul_b = 26'(c_q);      end
      ST_MIX_B:   begin mul_a = 33'(mix_b_c);  mul_b = 26'(mix_cb);   end
      ST_SQ_MUL:  begin mul_a = 33'(t_q[idx_q]); mul_b = 26'(t_q[idx_q]); end
      ST_CR_A, ST_CR_B: begin mul_a = 33'(cr_a_c); mul_b = 26'(cr_b_c); end
      default: ;
    endcase
  end

  // Angle folding into [-90, 90] degrees
  always_comb begin
    fm0  = $signed({2'b00, mod_r_q});
    fneg = 1'b0;
    if (fm0 >= HALF_TURN) fm0 = fm0 - FULL_TURN;
    fm1 = fm0;
    if (fm0 > QUARTER_TURN) begin
      fm1  = fm0 - HALF_TURN;
      fneg = 1'b1;
    end else if (fm0 < -QUARTER_TURN) begin
      fm1  = fm0 + HALF_TURN;
      fneg = 1'b1;
    end
  end

  assign mod_sub = FULL_TURN_U << mod_cnt_q;

  // Divider feed and saturating sign restore
  always_comb begin
    t_abs       = t_q[idx_q][MIX_W-1] ? MIX_W'(-t_q[idx_q]) : MIX_W'(t_q[idx_q]);
    dv_dividend = DIV_W'(t_abs) << 21;
    if (len_q == '0) nrm_v = '0;
    else if (dv_quot >= DIV_W'(32768))
      nrm_v = t_q[idx_q][MIX_W-1] ? 16'sh8000 : 16'sh7fff;
    else if (t_q[idx_q][MIX_W-1]) nrm_v = -$signed({1'b0, dv_quot[14:0]});
    else nrm_v = $signed({1'b0, dv_quot[14:0]});
  end

  assign cor_start = (state_q == ST_CORD_GO);
  assign sq_start  = (state_q == ST_SQRT_GO);
  assign dv_start  = (state_q == ST_DIV_GO);

  cfu_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .angle_i (z_q),
    .done_o  (cor_done),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin)
  );

  cfu_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (SQ_W'({n2_q, 14'b0})),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  cfu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dv_start),
    .dividend_i (dv_dividend),
    .divisor_i  (len_q),
    .done_o     (dv_done),
    .quot_o     (dv_quot)
  );

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_acc) state_d = ST_EXEC;
      ST_EXEC: begin
        unique case (req_q)
          REQ_LOAD, REQ_MOVE_VEC: state_d = ST_DONE;
          REQ_MOVE_AXIS: state_d = (ax_q == AX_NONE) ? ST_DONE : ST_AX_MUL;
          REQ_ROTATE:    state_d = (ax_q == AX_NONE) ? ST_DONE : ST_MOD;
          default:       state_d = ST_DONE;
        endcase
      end
      ST_AX_MUL:  state_d = ST_AX_ADD;
      ST_AX_ADD:  state_d = last_idx ? ST_DONE : ST_AX_MUL;
      ST_MOD:     if (mod_cnt_q == '0) state_d = ST_FOLD;
      ST_FOLD:    state_d = ST_RAD_MUL;
      ST_RAD_MUL: state_d = ST_RAD_SH;
      ST_RAD_SH:  state_d = ST_CORD_GO;
      ST_CORD_GO: state_d = ST_CORDIC;
      ST_CORDIC:  if (cor_done) state_d = ST_MIX_A;
      ST_MIX_A:   state_d = ST_MIX_B;
      ST_MIX_B:   state_d = ST_MIX_C;
      ST_MIX_C:   state_d = last_idx ? ST_SQ_MUL : ST_MIX_A;
      ST_SQ_MUL:  state_d = ST_SQ_ACC;
      ST_SQ_ACC:  state_d = last_idx ? ST_SQRT_GO : ST_SQ_MUL;
      ST_SQRT_GO: state_d = ST_SQRT;
      ST_SQRT:    if (sq_done) state_d = ST_DIV_GO;
      ST_DIV_GO:  state_d = ST_DIV;
      ST_DIV:     if (dv_done) state_d = last_idx ? ST_CR_A : ST_DIV_GO;
      ST_CR_A:    state_d = ST_CR_B;
      ST_CR_B:    state_d = ST_CR_C;
      ST_CR_C:    state_d = last_idx ? ST_DONE : ST_CR_A;
      ST_DONE:    if (can_out) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Multiplier product register
  always_ff @(posedge clk_i) begin
    prod_q <= 59'(mul_a) * 59'(mul_b);
  end

  // Command beat capture and working registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q    <= req_e'(req_type_i);
      ax_q     <= axis_sel_i;
      amt_q    <= amount_i;
      vec_q[0] <= vec_x_i;
      vec_q[1] <= vec_y_i;
      vec_q[2] <= vec_z_i;
    end
    case (state_q)
      ST_EXEC: begin
        mod_r_q   <= amt_q[31] ? 34'(amt_q) + MOD_WRAP : 34'(amt_q);
        mod_cnt_q <= 5'(MOD_K);
      end
      ST_MOD: begin
        if (mod_r_q >= mod_sub) mod_r_q <= mod_r_q - mod_sub;
        if (mod_cnt_q != '0) mod_cnt_q <= mod_cnt_q - 5'd1;
      end
      ST_FOLD: begin
        m_q   <= 33'(fm1);
        neg_q <= fneg;
      end
      ST_RAD_SH: z_q <= 34'(prod_q >>> POS_FRAC_BITS);
      ST_CORDIC: begin
        if (cor_done) begin
          c_q <= neg_q ? -cor_cos : cor_cos;
          s_q <= neg_q ? -cor_sin : cor_sin;
        end
      end
      ST_MIX_B, ST_CR_B: acc_q <= 35'(prod_q);
      ST_MIX_C: begin
        t_q[idx_q] <= MIX_W'((36'(acc_q) + 36'(prod_q)) >>> 14);
        n2_q       <= '0;
      end
      ST_SQ_ACC: n2_q <= n2_q + NSQ_W'(prod_q);
      ST_SQRT:   if (sq_done) len_q <= sq_root;
      default: ;
    endcase
  end

  // Component counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE, ST_CORDIC: idx_q <= '0;
        ST_AX_ADD, ST_MIX_C, ST_SQ_ACC, ST_CR_C:
          idx_q <= last_idx ? 2'd0 : idx_q + 2'd1;
        ST_DIV: if (dv_done) idx_q <= last_idx ? 2'd0 : idx_q + 2'd1;
        default: ;
      endcase
    end
  end

  // Camera state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        pos_q[i]  <= '0;
        view_q[i] <= '0;
        up_q[i]   <= '0;
        rgt_q[i]  <= '0;
      end
    end else begin
      case (state_q)
        ST_EXEC: begin
          if (req_q == REQ_LOAD) begin
            unique case (ax_q)
              SEL_POS:   for (int i = 0; i < 3; i++) pos_q[i] <= vec_q[i];
              SEL_VIEW:  for (int i = 0; i < 3; i++) view_q[i] <= to_q14(vec_q[i]);
              SEL_UP:    for (int i = 0; i < 3; i++) up_q[i] <= to_q14(vec_q[i]);
              SEL_RIGHT: for (int i = 0; i < 3; i++) rgt_q[i] <= to_q14(vec_q[i]);
              default: ;
            endcase
          end else if (req_q == REQ_MOVE_VEC) begin
            for (int i = 0; i < 3; i++)
              pos_q[i] <= sat32(49'(pos_q[i]) + 49'(vec_q[i]));
          end
        end
        ST_AX_ADD:
          pos_q[idx_q] <= sat32(49'(pos_q[idx_q]) + 49'(prod_q >>> 14));
        ST_DIV: begin
          if (dv_done) begin
            if (ax_q == ROT_ROLL) rgt_q[idx_q] <= nrm_v;
            else view_q[idx_q] <= nrm_v;
          end
        end
        ST_CR_C: begin
          if (ax_q == ROT_YAW)
            rgt_q[idx_q] <= sat16(48'((36'(acc_q) - 36'(prod_q)) >>> 14));
          else
            up_q[idx_q] <= sat16(48'((36'(acc_q) - 36'(prod_q)) >>> 14));
        end
        default: ;
      endcase
    end
  end

  // Result beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && can_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && can_out) begin
      o_pos_q  <= pos_q;
      o_view_q <= view_q;
      o_up_q   <= up_q;
      o_rgt_q  <= rgt_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o   = o_pos_q[0];
  assign pos_y_o   = o_pos_q[1];
  assign pos_z_o   = o_pos_q[2];
  assign view_x_o  = o_view_q[0];
  assign view_y_o  = o_view_q[1];
  assign view_z_o  = o_view_q[2];
  assign up_x_o    = o_up_q[0];
  assign up_y_o    = o_up_q[1];
  assign up_z_o    = o_up_q[2];
  assign right_x_o = o_rgt_q[0];
  assign right_y_o = o_rgt_q[1];
  assign right_z_o = o_rgt_q[2];

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 2'd3) else $error("component index out of range");
  a_cor_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_done |-> state_q == ST_CORDIC) else $error("stray cordic done");
  a_sq_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> state_q == ST_SQRT) else $error("stray sqrt done");
  a_dv_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_done |-> state_q == ST_DIV) else $error("stray divide done");
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_EXEC) else $error("accepted beat not executed");

endmodule
`default_nettype wire

### tb/sv/tb_camera_frame_update.sv
`timescale 1ns / 1ps
module tb_camera_frame_update;
  import cfu_pkg::*;

  typedef longint vec3_t [3];
  typedef struct {
    longint pos [3];
    longint view [3];
    longint up [3];
    longint rgt [3];
  } frame_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic [1:0] req_type_i, axis_sel_i;
  logic signed [31:0] amount_i, vec_x_i, vec_y_i, vec_z_i;
  logic signed [31:0] pos_x_o, pos_y_o, pos_z_o;
  logic signed [15:0] view_x_o, view_y_o, view_z_o, up_x_o, up_y_o, up_z_o;
  logic signed [15:0] right_x_o, right_y_o, right_z_o;

  camera_frame_update dut (.*);

  // Arctangent steps, Q2.30
  localparam longint ATAN_STEP [24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};
  localparam longint ONE_POS = 64'sd1 << POS_FRAC_BITS;

  // Camera frame as the block should hold it
  vec3_t cam_pos, cam_view, cam_up, cam_rgt;
  frame_t frames_due [$];
  int errors = 0;
  bit quiet_in = 0, quiet_out = 0;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint clamp16(longint v);
    return clamp(v, -32768, 32767);
  endfunction

  function automatic longint clamp32(longint v);
    return clamp(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic longint pos_to_q14(longint v);
    if (POS_FRAC_BITS >= 14) return clamp16(v >>> (POS_FRAC_BITS - 14));
    return clamp16(v <<< (14 - POS_FRAC_BITS));
  endfunction

  function automatic longint int_sqrt(logic [63:0] n);
    logic [63:0] res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= res + bt) begin
        n = n - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return longint'(res);
  endfunction

  function automatic vec3_t cross3(vec3_t a, vec3_t b);
    vec3_t o;
    o[0] = clamp16((a[1] * b[2] - a[2] * b[1]) >>> 14);
    o[1] = clamp16((a[2] * b[0] - a[0] * b[2]) >>> 14);
    o[2] = clamp16((a[0] * b[1] - a[1] * b[0]) >>> 14);
    return o;
  endfunction

  // Blend two vectors and scale the blend back to unit length
  function automatic vec3_t blend_unit(vec3_t a, longint ca, vec3_t b, longint cb);
    vec3_t t, o;
    logic [63:0] n2;
    longint len;
    n2 = 0;
    for (int i = 0; i < 3; i++) begin
      t[i] = (a[i] * ca + b[i] * cb) >>> 14;
      n2 = n2 + 64'(t[i] * t[i]);
    end
    len = int_sqrt(n2 << 14);
    for (int i = 0; i < 3; i++) o[i] = (len == 0) ? 0 : clamp16((t[i] * 2097152) / len);
    return o;
  endfunction

  // Angle in degrees to Q1.14 cosine and sine
  task automatic angle_trig(input longint deg, output longint c, output longint s);
    longint full, half, qtr, m, x, y, z, nx;
    bit flip;
    full = 64'sd360 << POS_FRAC_BITS;
    half = 64'sd180 << POS_FRAC_BITS;
    qtr = 64'sd90 << POS_FRAC_BITS;
    flip = 0;
    m = deg % full;
    if (m < 0) m += full;
    if (m >= half) m -= full;
    if (m > qtr) begin
      m -= half; flip = 1;
    end else if (m < -qtr) begin
      m += half; flip = 1;
    end
    z = (m * 18740330) >>> POS_FRAC_BITS;
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= ATAN_STEP[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += ATAN_STEP[i];
      end
      x = nx;
    end
    x = (x + 32768) >>> 16;
    y = (y + 32768) >>> 16;
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // Apply one command to the expected frame
  task automatic update_frame(input req_e rq, input logic [1:0] ax,
                              input longint amt, input vec3_t v);
    longint c, s;
    frame_t f;
    case (rq)
      REQ_LOAD: begin
        for (int i = 0; i < 3; i++)
          case (ax)
            SEL_POS:  cam_pos[i] = v[i];
            SEL_VIEW: cam_view[i] = pos_to_q14(v[i]);
            SEL_UP:   cam_up[i] = pos_to_q14(v[i]);
            default:  cam_rgt[i] = pos_to_q14(v[i]);
          endcase
      end
      REQ_MOVE_VEC: for (int i = 0; i < 3; i++) cam_pos[i] = clamp32(cam_pos[i] + v[i]);
      REQ_MOVE_AXIS: begin
        for (int i = 0; i < 3; i++)
          case (ax)
            MOV_VIEW:  cam_pos[i] = clamp32(cam_pos[i] + ((amt * cam_view[i]) >>> 14));
            MOV_RIGHT: cam_pos[i] = clamp32(cam_pos[i] + ((amt * cam_rgt[i]) >>> 14));
            MOV_UP:    cam_pos[i] = clamp32(cam_pos[i] + ((amt * cam_up[i]) >>> 14));
            default: ;
          endcase
      end
      default: begin
        if (ax != AX_NONE) begin
          angle_trig(amt, c, s);
          case (ax)
            ROT_PITCH: begin
              cam_view = blend_unit(cam_view, c, cam_up, s);
              cam_up = cross3(cam_rgt, cam_view);
            end
            ROT_YAW: begin
              cam_view = blend_unit(cam_view, c, cam_rgt, -s);
              cam_rgt = cross3(cam_view, cam_up);
            end
            default: begin
              cam_rgt = blend_unit(cam_rgt, c, cam_up, s);
              cam_up = cross3(cam_rgt, cam_view);
            end
          endcase
        end
      end
    endcase
    f.pos = cam_pos; f.view = cam_view; f.up = cam_up; f.rgt = cam_rgt;
    frames_due.push_back(f);
  endtask

  // Clock and time limit
  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("camera_frame_update test failed");
    $finish;
  end

  // Send one command beat; returns at the edge that accepts it
  task automatic send_cmd(input req_e rq, input logic [1:0] ax, input logic [31:0] amt,
                          input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    int gap;
    bit stalled;
    vec3_t v;
    gap = quiet_in ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= rq; axis_sel_i <= ax; amount_i <= amt;
    vec_x_i <= x; vec_y_i <= y; vec_z_i <= z;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    v[0] = longint'($signed(x)); v[1] = longint'($signed(y)); v[2] = longint'($signed(z));
    update_frame(rq, ax, longint'($signed(amt)), v);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Result side: random stall per beat, compare at acceptance
  initial begin
    frame_t f, want;
    bit seen;
    int n;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      n = quiet_out ? 0 : $urandom_range(0, 8);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do begin
        @(negedge clk_i);
        seen = out_valid_o;
        f.pos = '{pos_x_o, pos_y_o, pos_z_o};
        f.view = '{view_x_o, view_y_o, view_z_o};
        f.up = '{up_x_o, up_y_o, up_z_o};
        f.rgt = '{right_x_o, right_y_o, right_z_o};
        @(posedge clk_i);
      end while (!seen);
      if (frames_due.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = frames_due.pop_front();
        check_field("pos_x", want.pos[0], f.pos[0]);
        check_field("pos_y", want.pos[1], f.pos[1]);
        check_field("pos_z", want.pos[2], f.pos[2]);
        check_field("view_x", want.view[0], f.view[0]);
        check_field("view_y", want.view[1], f.view[1]);
        check_field("view_z", want.view[2], f.view[2]);
        check_field("up_x", want.up[0], f.up[0]);
        check_field("up_y", want.up[1], f.up[1]);
        check_field("up_z", want.up[2], f.up[2]);
        check_field("right_x", want.rgt[0], f.rgt[0]);
        check_field("right_y", want.rgt[1], f.rgt[1]);
        check_field("right_z", want.rgt[2], f.rgt[2]);
      end
    end
  end

  // Canonical orthonormal frame
  task automatic load_unit_frame();
    send_cmd(REQ_LOAD, SEL_VIEW, 0, 0, 0, 32'(ONE_POS));
    send_cmd(REQ_LOAD, SEL_UP, 0, 0, 32'(ONE_POS), 0);
    send_cmd(REQ_LOAD, SEL_RIGHT, 0, 32'(ONE_POS), 0, 0);
  endtask

  // Zero frame: moves do nothing, rotation normalises a zero vector
  task automatic test_zero_frame();
    send_cmd(REQ_MOVE_AXIS, MOV_VIEW, 32'h7fffffff, 0, 0, 0);
    send_cmd(REQ_ROTATE, ROT_PITCH, 32'(45 * ONE_POS), 0, 0, 0);
  endtask

  // Loads at the extremes, saturating basis conversion
  task automatic test_loads();
    send_cmd(REQ_LOAD, SEL_POS, 32'hdeadbeef, 32'h7fffffff, 32'h80000000, 32'hffffffff);
    send_cmd(REQ_LOAD, SEL_VIEW, 0, 32'h7fffffff, 32'h80000000, 32'hffffffff);
    send_cmd(REQ_LOAD, SEL_UP, 0, 32'h0001ffff, 32'hfffe0000, 32'h00000003);
    send_cmd(REQ_LOAD, SEL_RIGHT, 0, 32'h00020000, 32'hfffdffff, 32'h80000000);
  endtask

  // Vector and axis moves, with saturation both ways
  task automatic test_moves();
    load_unit_frame();
    send_cmd(REQ_MOVE_VEC, AX_NONE, 32'h12345678, 32'h7fffffff, 32'h80000000, 32'h1);
    send_cmd(REQ_MOVE_VEC, SEL_POS, 0, 32'h80000000, 32'h7fffffff, 32'hffffffff);
    send_cmd(REQ_MOVE_AXIS, MOV_VIEW, 32'h80000000, 32'h5555aaaa, 0, 0);
    send_cmd(REQ_MOVE_AXIS, MOV_RIGHT, 32'h7fffffff, 0, 0, 0);
    send_cmd(REQ_MOVE_AXIS, MOV_UP, 32'hffff0000, 0, 0, 0);
  endtask

  // Rotations, fold-over angles, ignored fourth axis
  task automatic test_rotations();
    send_cmd(REQ_ROTATE, ROT_PITCH, 32'(90 * ONE_POS), 0, 0, 0);
    send_cmd(REQ_ROTATE, ROT_YAW, 32'(-180 * ONE_POS), 0, 0, 0);
    send_cmd(REQ_ROTATE, ROT_ROLL, 32'(359 * ONE_POS), 0, 0, 0);
    send_cmd(REQ_ROTATE, ROT_PITCH, 32'h80000000, 0, 0, 0);
    send_cmd(REQ_ROTATE, ROT_YAW, 32'h7fffffff, 0, 0, 0);
    send_cmd(REQ_ROTATE, AX_NONE, 32'(30 * ONE_POS), 32'hffffffff, 0, 0);
    send_cmd(REQ_MOVE_AXIS, AX_NONE, 32'(5 * ONE_POS), 0, 0, 0);
  endtask

  function automatic logic [31:0] small_angle();
    return $urandom_range(0, 3) == 0 ? $urandom() : 32'($signed($urandom_range(0, 1440 * 64))
           - 720 * 64) <<< (POS_FRAC_BITS - 6);
  endfunction

  // Mostly sensible camera sessions, some raw noise
  task automatic test_random(int count);
    logic [1:0] ax;
    logic signed [31:0] c;
    for (int k = 0; k < count; k++) begin
      if (k % 150 == 0) begin
        quiet_in = (k % 600 == 300);
        quiet_out = (k % 450 == 150);
      end
      if (k == count / 2) drain();
      ax = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 15))
        0: load_unit_frame();
        1: begin
          c = $signed($urandom_range(0, 4 * 65536)) - 2 * 65536;
          send_cmd(REQ_LOAD, ax, $urandom(), 32'(c) <<< (POS_FRAC_BITS - 16),
                   $urandom(), $urandom_range(0, 1) ? $urandom() : 32'(ONE_POS));
        end
        2: send_cmd(REQ_LOAD, ax, $urandom(), $urandom(), $urandom(), $urandom());
        3, 4: send_cmd(REQ_MOVE_VEC, ax, $urandom(), $urandom() >>> $urandom_range(0, 12),
                       $urandom(), $urandom() >>> 8);
        5, 6, 7: send_cmd(REQ_MOVE_AXIS, ax, $urandom_range(0, 1) ? $urandom() :
                          32'($signed($urandom_range(0, 2000)) - 1000) <<< 10,
                          $urandom(), $urandom(), $urandom());
        default: send_cmd(REQ_ROTATE, ax, small_angle(), $urandom(), $urandom(), $urandom());
      endcase
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    req_type_i = '0; axis_sel_i = '0;
    amount_i = '0; vec_x_i = '0; vec_y_i = '0; vec_z_i = '0;
    cam_pos = '{0, 0, 0}; cam_view = '{0, 0, 0}; cam_up = '{0, 0, 0}; cam_rgt = '{0, 0, 0};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_frame();
    test_loads();
    test_moves();
    test_rotations();
    test_random(1190);
    drain();
    repeat (300) @(posedge clk_i);
    if (errors == 0 && frames_due.size() == 0) begin
      $display("camera_frame_update test passed");
    end else begin
      $display("camera_frame_update test failed");
    end
    $finish;
  end

endmodule
